// ===== src/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
// No dependencies; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk_s, rst_s, a, c)
`define ASSERT_NEXT(lbl, clk_s, rst_s, a, c)
`endif
`endif

// ===== src/pdlm_pkg.sv =====
// Package for the duty load monitor: states, command struct, constants.
// Used by the controller, datapath and top level.
package pdlm_pkg;
  localparam int OUT_CH   = 4;
  localparam int QUO_BITS = 16;
  localparam logic [15:0] HALF_Q88 = 16'd12800;
  localparam logic [8:0]  LOAD_MAX = 9'd511;

  localparam logic [2:0] REG_MOTOR_COUNT = 3'd0;
  localparam logic [2:0] REG_MON_ENABLE  = 3'd1;
  localparam logic [2:0] REG_TIMEOUT     = 3'd2;
  localparam logic [2:0] REG_ADJUST0     = 3'd3;
  localparam logic [2:0] REG_ADJUST3     = 3'd6;

  localparam logic [2:0]  RST_MOTOR_COUNT = 3'd3;
  localparam logic [19:0] RST_TIMEOUT     = 20'd10000;
  localparam logic [15:0] RST_ADJUST      = 16'd22144;

  localparam logic [1:0] ST_MEASURED  = 2'd0;
  localparam logic [1:0] ST_STATIC    = 2'd1;
  localparam logic [1:0] ST_NO_SIGNAL = 2'd2;
  localparam logic [1:0] ST_NOT_MON   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_FIN, S_PUSH
  } state_t;

  typedef struct packed {
    logic       tick;
    logic       mul;
    logic       div;
    logic       fin;
    logic       push;
    logic [1:0] ch;
  } cmd_t;
endpackage

// ===== src/pdlm_ctrl.sv =====
// Controller: sequences tick update, per-channel multiply/divide and result push.
// Depends on pdlm_pkg.
module pdlm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output pdlm_pkg::cmd_t cmd
);
  import pdlm_pkg::*;

  state_t state, state_next;
  logic [1:0] ch;
  logic [3:0] step;
  logic       out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (step == 4'(QUO_BITS - 1)) state_next = S_FIN;
      S_FIN:  state_next = (ch == 2'(OUT_CH - 1)) ? S_PUSH : S_MUL;
      S_PUSH: if (!out_valid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.tick = s_tvalid;
      end
      S_MUL:  cmd.mul  = 1'b1;
      S_DIV:  cmd.div  = 1'b1;
      S_FIN:  cmd.fin  = 1'b1;
      S_PUSH: cmd.push = !out_valid || m_tready;
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) ch <= '0;
      else if (state == S_FIN) ch <= ch + 2'd1;
      if (state == S_DIV) step <= step + 4'd1;
      else step <= '0;
      if (cmd.push) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== src/pdlm_dp.sv =====
// Datapath: config registers, run timers, multiplier, restoring divider, load.
// Depends on pdlm_pkg; driven by pdlm_ctrl commands.
module pdlm_dp #(
  parameter int CHANNELS   = 4,
  parameter int TIMER_BITS = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  pdlm_pkg::cmd_t cmd,
  input  logic [3:0]     pins,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [19:0]    cfg_data,
  output logic [47:0]    result
);
  import pdlm_pkg::*;

  localparam int RW = TIMER_BITS + 1;           // run length / width
  localparam int CW = (RW > 20) ? RW : 20;      // compare width
  localparam int PDW = RW + 1;                  // period
  localparam int PW = RW + QUO_BITS;            // product / remainder

  logic [2:0]  motor_count;
  logic        mon_en;
  logic [19:0] timeout;
  logic [15:0] adjust [OUT_CH];

  logic          last_level [CHANNELS];
  logic [RW-1:0] run_len    [CHANNELS];
  logic          counted    [CHANNELS];
  logic [RW-1:0] low_w      [CHANNELS];
  logic [RW-1:0] high_w     [CHANNELS];

  logic          last_level_next [CHANNELS];
  logic [RW-1:0] run_len_next    [CHANNELS];
  logic          counted_next    [CHANNELS];
  logic [RW-1:0] low_w_next      [CHANNELS];
  logic [RW-1:0] high_w_next     [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_count <= RST_MOTOR_COUNT;
      mon_en      <= 1'b1;
      timeout     <= RST_TIMEOUT;
      for (int i = 0; i < OUT_CH; i++) adjust[i] <= RST_ADJUST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MOTOR_COUNT) motor_count <= cfg_data[2:0];
      else if (cfg_index == REG_MON_ENABLE) mon_en <= cfg_data[0];
      else if (cfg_index == REG_TIMEOUT) timeout <= cfg_data;
      else if (cfg_index >= REG_ADJUST0 && cfg_index <= REG_ADJUST3)
        adjust[2'(cfg_index - REG_ADJUST0)] <= cfg_data[15:0];
    end
  end

  // per-channel run timing, all channels in parallel
  always_comb begin
    logic lvl;
    logic [RW-1:0] w;
    for (int n = 0; n < CHANNELS; n++) begin
      lvl = (n < 4) ? pins[n] : 1'b1;
      last_level_next[n] = last_level[n];
      run_len_next[n]    = run_len[n];
      counted_next[n]    = counted[n];
      low_w_next[n]      = low_w[n];
      high_w_next[n]     = high_w[n];
      w = (CW'(run_len[n]) > CW'(timeout)) ? '0 : run_len[n];
      if (lvl == last_level[n]) begin
        if (run_len[n] != {RW{1'b1}}) run_len_next[n] = run_len[n] + 1'b1;
      end else begin
        if (counted[n]) begin
          if (!last_level[n]) low_w_next[n] = w;
          else high_w_next[n] = w;
        end
        counted_next[n]    = 1'b1;
        run_len_next[n]    = RW'(1);
        last_level_next[n] = lvl;
      end
      if (CW'(run_len_next[n]) > CW'(timeout)) begin
        low_w_next[n]  = '0;
        high_w_next[n] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < CHANNELS; n++) begin
        last_level[n] <= 1'b1;
        run_len[n]    <= '0;
        counted[n]    <= 1'b0;
        low_w[n]      <= '0;
        high_w[n]     <= '0;
      end
    end else if (cmd.tick) begin
      last_level <= last_level_next;
      run_len    <= run_len_next;
      counted    <= counted_next;
      low_w      <= low_w_next;
      high_w     <= high_w_next;
    end
  end

  // selected channel
  logic [RW-1:0] sel_low, sel_high;
  logic          sel_lvl, ch_mon;
  always_comb begin
    sel_low  = '0;
    sel_high = '0;
    sel_lvl  = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (4'(i) == {2'b00, cmd.ch}) begin
        sel_low  = low_w[i];
        sel_high = high_w[i];
        sel_lvl  = last_level[i];
      end
    end
    ch_mon = mon_en && ({2'b00, cmd.ch} < 4'(CHANNELS)) && ({1'b0, cmd.ch} < motor_count);
  end

  // multiply then restoring division, one quotient bit a cycle
  logic [PDW-1:0]      period;
  logic [PW-1:0]       rem, dsr;
  logic [QUO_BITS-1:0] quo;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      period <= PDW'(sel_low) + PDW'(sel_high);
      rem    <= PW'(sel_low) * PW'(adjust[cmd.ch]);
      dsr    <= PW'(PDW'(sel_low) + PDW'(sel_high)) << (QUO_BITS - 1);
      quo    <= '0;
    end else if (cmd.div) begin
      if (rem >= dsr) begin
        rem <= rem - dsr;
        quo <= {quo[QUO_BITS-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_BITS-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

  // load from duty
  logic [15:0] diff;
  logic [17:0] rsum;
  logic [8:0]  load_val;
  always_comb begin
    diff     = (quo >= HALF_Q88) ? quo - HALF_Q88 : HALF_Q88 - quo;
    rsum     = {1'b0, diff, 1'b0} + 18'd128;
    load_val = rsum[17] ? LOAD_MAX : rsum[16:8];
  end

  logic [8:0] ld   [OUT_CH];
  logic [1:0] st   [OUT_CH];
  logic       fail;

  always_ff @(posedge clk) begin
    if (cmd.tick) fail <= 1'b0;
    if (cmd.fin) begin
      if (!ch_mon) begin
        st[cmd.ch] <= ST_NOT_MON;
        ld[cmd.ch] <= '0;
      end else if (period != '0) begin
        st[cmd.ch] <= ST_MEASURED;
        ld[cmd.ch] <= load_val;
      end else if (!sel_lvl) begin
        st[cmd.ch] <= ST_STATIC;
        ld[cmd.ch] <= '0;
      end else begin
        st[cmd.ch] <= ST_NO_SIGNAL;
        ld[cmd.ch] <= '0;
        fail       <= 1'b1;
      end
    end
    if (cmd.push)
      result <= {3'b000, fail, st[3], st[2], st[1], st[0], ld[3], ld[2], ld[1], ld[0]};
  end
endmodule

// ===== src/pwm_duty_load_monitor.sv =====
// One input item is one sample tick of four active-low feedback lines; one result
// carries load and status of every channel. Items are handled one at a time:
// each channel passes through a multiply step, the shared restoring divider and
// a finishing step, in sequence; the push then waits while the output is held.
// The first partial run after reset is discarded. Depends on pdlm_pkg,
// pdlm_ctrl, pdlm_dp and assert_macros.svh.
`include "assert_macros.svh"
module pwm_duty_load_monitor #(
  parameter int CHANNELS   = 4,
  parameter int TIMER_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] pin_levels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // load_ch0..3 (9 each), status_ch0..3 (2 each),
                                 // motor_failure, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import pdlm_pkg::*;

  cmd_t cmd;

  pdlm_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd
  );

  pdlm_dp #(.CHANNELS(CHANNELS), .TIMER_BITS(TIMER_BITS)) u_dp (
    .clk, .rst, .cmd, .pins(s_tdata[3:0]), .cfg_we, .cfg_index, .cfg_data,
    .result(m_tdata)
  );

  `ASSERT_NEXT(a_leave_idle, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_fail_has_cause, clk, rst, m_tvalid && m_tdata[44], m_tdata[37:36] == ST_NO_SIGNAL || m_tdata[39:38] == ST_NO_SIGNAL || m_tdata[41:40] == ST_NO_SIGNAL || m_tdata[43:42] == ST_NO_SIGNAL)
  `ASSERT_IMPL(a_load_only_measured, clk, rst, m_tvalid && m_tdata[37:36] != ST_MEASURED, m_tdata[8:0] == 9'd0)
endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for pwm_duty_load_monitor: sends ticks of feedback line levels,
// predicts load and status of every channel, checks each result. Depends on pdlm_pkg.
module tb_top;
  import pdlm_pkg::*;

  typedef struct packed {
    logic            fail;
    logic [3:0][1:0] status;
    logic [3:0][8:0] load;
  } load_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // model state and registers
  logic [3:0]       lvl_q;
  logic [20:0]      run_q [4];
  logic [3:0]       counted_q;
  logic [19:0]      low_q [4];
  logic [19:0]      high_q [4];
  logic [2:0]       cnt_r;
  logic             en_r;
  logic [19:0]      tmo_r;
  logic [15:0]      adj_r [4];

  load_report_t     reports_due [$];
  int               send_idle = 0;
  int               recv_idle = 0;
  int               errors = 0;

  // per-channel waveform generator
  logic [3:0]       wave_lvl;
  int               wave_left [4];

  pwm_duty_load_monitor DUT (.*);

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic load_report_t tick_predict(logic [3:0] pins);
    load_report_t r;
    logic [19:0]  w;
    logic [20:0]  period;
    logic [35:0]  duty;
    logic [35:0]  diff;
    logic [36:0]  ld;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      if (pins[n] == lvl_q[n]) begin
        if (run_q[n] != 21'h1FFFFF) run_q[n]++;
      end else begin
        if (counted_q[n]) begin
          w = (run_q[n] > {1'b0, tmo_r}) ? 20'd0 : run_q[n][19:0];
          if (lvl_q[n] == 1'b0) low_q[n] = w;
          else high_q[n] = w;
        end
        counted_q[n] = 1'b1;
        run_q[n] = 21'd1;
        lvl_q[n] = pins[n];
      end
      if (run_q[n] > {1'b0, tmo_r}) begin
        low_q[n] = '0;
        high_q[n] = '0;
      end
    end
    for (int n = 0; n < 4; n++) begin
      r.status[n] = ST_NOT_MON;
      if (en_r && n < cnt_r) begin
        period = low_q[n] + high_q[n];
        if (period != 0) begin
          duty = (36'(low_q[n]) * adj_r[n]) / period;
          diff = (duty >= HALF_Q88) ? duty - HALF_Q88 : HALF_Q88 - duty;
          ld = (2 * diff + 128) >> 8;
          r.load[n] = (ld > LOAD_MAX) ? LOAD_MAX : ld[8:0];
          r.status[n] = ST_MEASURED;
        end else if (lvl_q[n] == 1'b0) begin
          r.status[n] = ST_STATIC;
        end else begin
          r.status[n] = ST_NO_SIGNAL;
          r.fail = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // one tick request; valid stays up across back-to-back requests
  task automatic send_tick(logic [3:0] pins);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tdata  <= {4'b0, pins};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    reports_due.push_back(tick_predict(pins));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MOTOR_COUNT: cnt_r = val[2:0];
      REG_MON_ENABLE:  en_r  = val[0];
      REG_TIMEOUT:     tmo_r = val;
      default:         adj_r[2'(idx - REG_ADJUST0)] = val[15:0];
    endcase
  endtask

  always @(posedge clk) begin
    load_report_t got, want;
    m_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[44:0];
      if (reports_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = reports_due.pop_front();
        if (got != want || m_tdata[47:45] != 3'b0) begin
          errors++;
          if (errors <= 10)
            for (int n = 0; n < 4; n++)
              $display("ch%0d load exp %0d got %0d, status exp %0d got %0d, fail exp %b got %b",
                       n, want.load[n], got.load[n], want.status[n], got.status[n],
                       want.fail, got.fail);
        end
      end
    end
  end

  // reset defaults; first partial run is thrown away, then a 1:1 square wave
  task automatic test_reset_defaults;
    for (int i = 0; i < 6; i++) send_tick((i % 2) ? 4'hF : 4'h0);
    drain();
  endtask

  // zero timeout forces static or no signal, scale extremes, all channels, disabled monitoring
  task automatic test_extremes;
    write_reg(REG_TIMEOUT, 20'd0);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h5);
    drain();
    write_reg(REG_MOTOR_COUNT, 20'd7);
    write_reg(REG_TIMEOUT, 20'd2);
    write_reg(REG_ADJUST0, 20'd0);
    write_reg(REG_ADJUST0 + 3'd1, 20'hFFFFF);
    write_reg(REG_ADJUST0 + 3'd2, 20'd0);
    write_reg(REG_ADJUST3, 20'hFFFF);
    for (int i = 0; i < 8; i++) send_tick((i % 3) ? 4'hA : 4'h5);
    for (int i = 0; i < 4; i++) send_tick(4'h3);   // open runs past timeout
    drain();
    write_reg(REG_MON_ENABLE, 20'd0);
    send_tick(4'h0);
    send_tick(4'hF);
    drain();
    write_reg(REG_MOTOR_COUNT, 20'd0);
    write_reg(REG_MON_ENABLE, 20'd1);
    send_tick(4'hF);
    drain();
  endtask

  task automatic test_random_pwm(int phase);
    int tv, lim;
    logic [3:0] pins;
    write_reg(REG_MOTOR_COUNT, 20'($urandom_range(7)));
    write_reg(REG_MON_ENABLE, 20'($urandom_range(5) != 0));
    case ($urandom_range(4))
      0:       tv = 0;
      1:       tv = 1;
      2:       tv = 20'hFFFFF;
      default: tv = $urandom_range(40, 2);
    endcase
    if (phase == 0) tv = 20'hFFFFF;
    write_reg(REG_TIMEOUT, 20'(tv));
    for (int n = 0; n < 4; n++)
      case ($urandom_range(5))
        0:       write_reg(3'(REG_ADJUST0 + n), 20'd0);
        1:       write_reg(3'(REG_ADJUST0 + n), 20'hFFFF);
        default: write_reg(3'(REG_ADJUST0 + n), 20'($urandom));
      endcase
    lim = (tv > 30) ? 30 : tv + 3;
    for (int n = 0; n < 4; n++) wave_left[n] = $urandom_range(lim + 1, 1);
    wave_lvl = 4'($urandom);
    for (int i = 0; i < 75; i++) begin
      for (int n = 0; n < 4; n++)
        if (--wave_left[n] <= 0) begin
          wave_lvl[n] = ~wave_lvl[n];
          wave_left[n] = ($urandom_range(9) == 0) ? $urandom_range(lim + 10, 1)
                                                  : $urandom_range(lim + 1, 1);
        end
      pins = ($urandom_range(9) == 0) ? 4'($urandom) : wave_lvl;
      send_tick(pins);
    end
    drain();
  endtask

  initial begin
    lvl_q = 4'hF;
    counted_q = '0;
    for (int n = 0; n < 4; n++) begin
      run_q[n] = '0;
      low_q[n] = '0;
      high_q[n] = '0;
      adj_r[n] = RST_ADJUST;
    end
    cnt_r = RST_MOTOR_COUNT;
    en_r  = 1'b1;
    tmo_r = RST_TIMEOUT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle = 31;
    recv_idle = 82;
    test_reset_defaults();
    test_extremes();
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 82;
        recv_idle = 31;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      test_random_pwm(p);
    end
    repeat (200) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
